[design/olid_pkg.sv]
`default_nettype none

package olid_pkg;

    localparam int SLOTS        = 16;
    localparam int CAPACITY_DEF = 16;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 4;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_END   = 3'd1,
        MODE_DELETE    = 3'd2,
        MODE_SEARCH    = 3'd3,
        MODE_LIST      = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DELETED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_EMPTY     = 3'd4,
        STAT_FULL      = 3'd5,
        STAT_LISTED    = 3'd6
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LIST = 1'b1
    } t_state;

    typedef struct packed {
        logic ins_front;
        logic ins_end;
        logic del;
        logic rotate;
    } t_cell_ctl;

endpackage

`default_nettype wire

[design/ordered_list_insert_delete_search.sv]
// Ordered list of signed 32-bit values held in a row of cells.
// Input channel: i_valid / o_stall with i_mode and i_value; a transaction
// is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_status, o_item_value,
// o_position and o_last; a result is taken when o_valid is high and
// i_stall low.
// Delete and search compare every cell in parallel, and insert and delete
// shift the row at acceptance: the result appears in the next cycle, and
// a new transaction can be taken every cycle while the output register drains.
// Listing moves to a list state at acceptance, then rotates the row one cell
// per cycle while the output register is free, giving one entry per cycle;
// the input is stalled until the last entry has been loaded into the output
// register.
// When the receiver stalls, the result holds in the output register and
// o_stall stays high for as long as a held result is stalled.
// Reset (synchronous, active low) empties the list and clears the output
// valid; cell contents are left as they are. Modes 5 to 7 give no result.
`default_nettype none

module ordered_list_insert_delete_search #(
    parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [2:0]        i_mode,
    input  wire logic signed [31:0] i_value,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [2:0]             o_status,
    output logic signed [31:0]     o_item_value,
    output logic [3:0]             o_position,
    output logic                   o_last,
    input  wire logic              i_stall
);
    import olid_pkg::*;

    localparam int CELLS = (CAPACITY < SLOTS) ? CAPACITY : SLOTS;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int IW    = $clog2(CELLS);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [IW-1:0]           r_idx, n_idx;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic signed [VAL_W-1:0] r_item, n_item;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic                    r_last, n_last;

    t_cell_ctl               ctl;
    logic signed [VAL_W-1:0] vals [CELLS];
    logic                    hit  [CELLS+1];
    logic                    occupied [CELLS];
    logic                    tail [CELLS];
    logic [IW-1:0]           first_pos;
    logic                    found;
    logic                    full;
    logic                    empty;
    logic                    out_free;
    logic                    accept;

    assign hit[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            logic signed [VAL_W-1:0] prev_val;
            logic signed [VAL_W-1:0] next_val;

            assign occupied[g] = CW'(g) < r_count;
            assign tail[g]     = r_count == CW'(g);

            if (g == 0) begin : g_head
                assign prev_val = i_value;
            end else begin : g_body
                assign prev_val = vals[g-1];
            end

            if (g == CELLS - 1) begin : g_end
                assign next_val = vals[0];
            end else begin : g_mid
                assign next_val = (r_count == CW'(g + 1)) ? vals[0] : vals[g+1];
            end

            olid_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_occupied (occupied[g]),
                .i_tail     (tail[g]),
                .i_key      (i_value),
                .i_prev_val (prev_val),
                .i_next_val (next_val),
                .i_hit_in   (hit[g]),
                .o_value    (vals[g]),
                .o_hit_out  (hit[g+1])
            );
        end
    endgenerate

    // first matching cell from the front
    always_comb begin
        first_pos = '0;
        for (int i = CELLS - 1; i >= 0; i--) begin
            if (hit[i+1] && !hit[i]) begin
                first_pos = IW'(i);
            end
        end
    end

    assign found    = hit[CELLS];
    assign full     = r_count == CW'(CELLS);
    assign empty    = r_count == '0;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state == ST_LIST) || !out_free;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_item      = r_item;
        n_pos       = r_pos;
        n_last      = r_last;
        ctl         = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item = i_value;
                    n_pos  = '0;
                    n_last = 1'b1;
                    case (t_mode'(i_mode))
                        MODE_INS_FRONT: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_status      = STAT_INSERTED;
                                ctl.ins_front = 1'b1;
                                n_count       = r_count + 1'b1;
                            end
                        end
                        MODE_INS_END: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_status    = STAT_INSERTED;
                                n_pos       = POS_W'(r_count);
                                ctl.ins_end = 1'b1;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        MODE_DELETE: begin
                            n_out_valid = 1'b1;
                            if (empty) begin
                                n_status = STAT_EMPTY;
                            end else if (!found) begin
                                n_status = STAT_NOT_FOUND;
                            end else begin
                                n_status = STAT_DELETED;
                                n_pos    = POS_W'(first_pos);
                                ctl.del  = 1'b1;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        MODE_SEARCH: begin
                            n_out_valid = 1'b1;
                            if (empty) begin
                                n_status = STAT_EMPTY;
                            end else if (!found) begin
                                n_status = STAT_NOT_FOUND;
                            end else begin
                                n_status = STAT_FOUND;
                                n_pos    = POS_W'(first_pos);
                            end
                        end
                        MODE_LIST: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_status    = STAT_EMPTY;
                                n_item      = '0;
                            end else begin
                                n_state = ST_LIST;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = STAT_LISTED;
                    n_item      = vals[0];
                    n_pos       = POS_W'(r_idx);
                    n_last      = CW'(r_idx) == r_count - 1'b1;
                    ctl.rotate  = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    if (n_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_item   <= n_item;
        r_pos    <= n_pos;
        r_last   <= n_last;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_item_value = r_item;
    assign o_position   = r_pos;
    assign o_last       = r_last;

endmodule

`default_nettype wire

[design/olid_cell.sv]
`default_nettype none

module olid_cell (
    input  wire logic                      i_clk,
    input  wire olid_pkg::t_cell_ctl       i_ctl,
    input  wire logic                      i_occupied,
    input  wire logic                      i_tail,
    input  wire logic signed [31:0]        i_key,
    input  wire logic signed [31:0]        i_prev_val,
    input  wire logic signed [31:0]        i_next_val,
    input  wire logic                      i_hit_in,
    output logic signed [31:0]             o_value,
    output logic                           o_hit_out
);
    import olid_pkg::*;

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;
    logic                    match;

    assign match     = i_occupied && (r_value == i_key);
    assign o_hit_out = i_hit_in | match;
    assign o_value   = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins_front) begin
            n_value = i_prev_val;
        end else if (i_ctl.ins_end && i_tail) begin
            n_value = i_key;
        end else if (i_ctl.rotate || (i_ctl.del && (i_hit_in || match))) begin
            n_value = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

[design/olid_checker.sv]
`default_nettype none

module olid_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic [2:0]        o_status,
    input wire logic              o_last,
    input wire logic              i_stall
);
    import olid_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_LISTED) |-> o_last)
        else $error("single result without last");

    a_list_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_status == STAT_LISTED && !o_last)
        |=> (o_valid && o_status == STAT_LISTED))
        else $error("listing interrupted");

    a_list_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_LISTED && !o_last) |-> o_stall)
        else $error("input taken during listing");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind ordered_list_insert_delete_search olid_checker u_olid_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_last   (o_last),
    .i_stall  (i_stall)
);

`default_nettype wire

[tb/tb_ordered_list_insert_delete_search.sv]
`timescale 1ns / 100ps

module tb_ordered_list_insert_delete_search;
    import olid_pkg::*;

    localparam int LIST_CAP = (CAPACITY_DEF < SLOTS) ? CAPACITY_DEF : SLOTS;
    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    typedef struct {
        t_status            status;
        logic signed [31:0] item_value;
        logic [3:0]         position;
        logic               last;
    } t_outcome;

    typedef struct {
        logic [2:0]         mode;
        logic signed [31:0] value;
        bit                 typed;
        t_status            status;
        logic signed [31:0] item_value;
        logic [3:0]         position;
    } t_stim;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic [2:0]         i_mode;
    logic signed [31:0] i_value;
    logic               o_stall;
    logic               o_valid;
    logic [2:0]         o_status;
    logic signed [31:0] o_item_value;
    logic [3:0]         o_position;
    logic               o_last;
    logic               i_stall;

    logic signed [31:0] list_mirror[$];
    t_outcome           awaited_results[$];
    int                 mismatch_count;
    int                 results_checked;
    int                 transactions_sent;
    int                 status_seen[8];
    int                 deepest_list;
    int                 burst_left;
    int                 idle_cycles;
    bit                 random_started;

    ordered_list_insert_delete_search i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_item_value (o_item_value),
        .o_position   (o_position),
        .o_last       (o_last),
        .i_stall      (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Updates the mirrored list and, if keep is set, queues the results due.
    function automatic void apply_list_op(input logic [2:0] mode,
                                          input logic signed [31:0] value,
                                          input bit keep);
        t_outcome res[$];
        t_outcome o;
        int       idx;
        idx = -1;
        o.status = STAT_EMPTY;
        o.item_value = value;
        o.position = '0;
        o.last = 1'b1;
        case (mode)
            MODE_INS_FRONT, MODE_INS_END: begin
                if (list_mirror.size() >= LIST_CAP) begin
                    o.status = STAT_FULL;
                end else begin
                    o.status = STAT_INSERTED;
                    if (mode == MODE_INS_FRONT) begin
                        list_mirror.push_front(value);
                    end else begin
                        list_mirror.push_back(value);
                        o.position = 4'(list_mirror.size() - 1);
                    end
                end
                res.push_back(o);
            end
            MODE_DELETE, MODE_SEARCH: begin
                foreach (list_mirror[i]) begin
                    if (idx < 0 && list_mirror[i] == value) idx = i;
                end
                if (list_mirror.size() == 0) begin
                    o.status = STAT_EMPTY;
                end else if (idx < 0) begin
                    o.status = STAT_NOT_FOUND;
                end else begin
                    o.position = 4'(idx);
                    if (mode == MODE_DELETE) begin
                        o.status = STAT_DELETED;
                        list_mirror.delete(idx);
                    end else begin
                        o.status = STAT_FOUND;
                    end
                end
                res.push_back(o);
            end
            MODE_LIST: begin
                if (list_mirror.size() == 0) begin
                    o.item_value = '0;
                    res.push_back(o);
                end else begin
                    foreach (list_mirror[i]) begin
                        o.status = STAT_LISTED;
                        o.item_value = list_mirror[i];
                        o.position = 4'(i);
                        o.last = (i == list_mirror.size() - 1);
                        res.push_back(o);
                    end
                end
            end
            default: ;
        endcase
        if (list_mirror.size() > deepest_list) deepest_list = list_mirror.size();
        if (keep) begin
            foreach (res[i]) awaited_results.push_back(res[i]);
        end
    endfunction

    // Offers one transaction, waits for it to be taken, then maybe idles.
    task automatic send_item(input t_stim s);
        t_outcome o;
        int       gap;
        i_valid <= 1'b1;
        i_mode  <= s.mode;
        i_value <= s.value;
        do @(posedge i_clk); while (o_stall);
        transactions_sent++;
        if (s.typed) begin
            apply_list_op(s.mode, s.value, 1'b0);
            o.status = s.status;
            o.item_value = s.item_value;
            o.position = s.position;
            o.last = 1'b1;
            awaited_results.push_back(o);
        end else begin
            apply_list_op(s.mode, s.value, 1'b1);
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 && list_mirror.size() != 0) begin
            return list_mirror[$urandom_range(0, list_mirror.size() - 1)];
        end else if (pick < 65) begin
            return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        end else if (pick < 75) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom);
    endfunction

    // Receiver: stall patterns in segments, plus one long hold-off.
    initial begin
        bit held;
        int pattern;
        held = 1'b0;
        i_stall = 1'b0;
        forever begin
            if (random_started && !held) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            pattern = $urandom_range(0, 3);
            repeat ($urandom_range(10, 40)) begin
                @(posedge i_clk);
                case (pattern)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= $urandom_range(0, 1);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked++;
            status_seen[o_status]++;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d value %0d position %0d",
                       o_status, o_item_value, o_position);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_item_value !== want.item_value) begin
                    $error("item_value: expected %0d, got %0d",
                           want.item_value, o_item_value);
                    mismatch_count++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_stim              rows[$];
        t_stim              s;
        logic signed [31:0] tail_value;
        int                 counted;
        int                 phase_left;
        bit                 grow;
        int                 pick;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = MODE_INS_FRONT;
        i_value = '0;
        idle_cycles = 0;
        mismatch_count = 0;
        results_checked = 0;
        transactions_sent = 0;
        deepest_list = 0;
        burst_left = 0;
        random_started = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;

        // empty list, extremes, lookups
        rows.push_back('{MODE_LIST, 32'sd77, 1'b1, STAT_EMPTY, 32'sd0, 4'd0});
        rows.push_back('{MODE_SEARCH, 32'sd5, 1'b1, STAT_EMPTY, 32'sd5, 4'd0});
        rows.push_back('{MODE_DELETE, -32'sd1, 1'b1, STAT_EMPTY, -32'sd1, 4'd0});
        rows.push_back('{MODE_INS_END, 32'sh7fff_ffff, 1'b1, STAT_INSERTED,
                         32'sh7fff_ffff, 4'd0});
        rows.push_back('{MODE_INS_FRONT, 32'sh8000_0000, 1'b1, STAT_INSERTED,
                         32'sh8000_0000, 4'd0});
        rows.push_back('{MODE_INS_END, 32'sd0, 1'b1, STAT_INSERTED, 32'sd0, 4'd2});
        rows.push_back('{MODE_SEARCH, 32'sd0, 1'b1, STAT_FOUND, 32'sd0, 4'd2});
        rows.push_back('{MODE_SEARCH, 32'sd12345, 1'b1, STAT_NOT_FOUND, 32'sd12345, 4'd0});
        rows.push_back('{MODE_UNUSED_LO, 32'sd9, 1'b0, STAT_EMPTY, 32'sd0, 4'd0});
        rows.push_back('{MODE_DELETE, 32'sh8000_0000, 1'b1, STAT_DELETED,
                         32'sh8000_0000, 4'd0});
        // fill to capacity, then full, list and delete of the tail
        tail_value = '0;
        for (int k = 2; k < LIST_CAP; k++) begin
            tail_value = $signed($urandom);
            s = '{(k % 2 == 0) ? MODE_INS_FRONT : MODE_INS_END, tail_value, 1'b0,
                  STAT_EMPTY, 32'sd0, 4'd0};
            rows.push_back(s);
        end
        rows.push_back('{MODE_INS_FRONT, -32'sd1, 1'b1, STAT_FULL, -32'sd1, 4'd0});
        rows.push_back('{MODE_INS_END, 32'sd3, 1'b1, STAT_FULL, 32'sd3, 4'd0});
        rows.push_back('{MODE_LIST, -32'sd5, 1'b0, STAT_EMPTY, 32'sd0, 4'd0});
        rows.push_back('{MODE_DELETE, tail_value, 1'b0, STAT_EMPTY, 32'sd0, 4'd0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_item(rows[k]);

        random_started = 1'b1;
        counted = 0;
        phase_left = 0;
        grow = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                grow = !grow;
                phase_left = $urandom_range(15, 30);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            s.typed = 1'b0;
            s.status = STAT_EMPTY;
            s.item_value = '0;
            s.position = '0;
            s.value = pick_value();
            if (pick < 5) begin
                s.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            end else if (pick < (grow ? 65 : 20)) begin
                s.mode = $urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_END;
            end else if (pick < (grow ? 80 : 75)) begin
                s.mode = MODE_DELETE;
            end else if (pick < 92) begin
                s.mode = MODE_SEARCH;
            end else begin
                s.mode = MODE_LIST;
            end
            send_item(s);
            if (s.mode < MODE_UNUSED_LO) counted++;
        end
        i_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d transactions sent, %0d results checked, list reached %0d of %0d",
                 transactions_sent, results_checked, deepest_list, LIST_CAP);
        $display("ins %0d del %0d found %0d miss %0d empty %0d full %0d listed %0d",
                 status_seen[STAT_INSERTED], status_seen[STAT_DELETED],
                 status_seen[STAT_FOUND], status_seen[STAT_NOT_FOUND],
                 status_seen[STAT_EMPTY], status_seen[STAT_FULL], status_seen[STAT_LISTED]);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
